// ===== hdl/mscnt_pkg.sv =====
// ----------------------------------------------------------------------------
// mscnt_pkg
// Shared types, widths and the control store of the fewest-squares sequencer.
// ----------------------------------------------------------------------------
package mscnt_pkg;

  localparam int TARGET_W    = 11;
  localparam int MIN_COUNT_W = 3;
  localparam int ENTRY_W     = 3;
  localparam int PC_W        = 4;

  localparam logic [ENTRY_W-1:0] BEST_INIT = 3'd7;

  // step addresses of the control store
  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 4'd1;
  localparam logic [PC_W-1:0] STEP_SEED  = 4'd2;
  localparam logic [PC_W-1:0] STEP_OUTER = 4'd3;
  localparam logic [PC_W-1:0] STEP_INNER = 4'd4;
  localparam logic [PC_W-1:0] STEP_WRITE = 4'd5;
  localparam logic [PC_W-1:0] STEP_READ  = 4'd6;
  localparam logic [PC_W-1:0] STEP_OUT   = 4'd7;
  localparam logic [PC_W-1:0] STEP_BAD   = 4'd8;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NOSTART   = 3'd2,
    COND_BAD       = 3'd3,
    COND_SEED_MORE = 3'd4,
    COND_I_GT_T    = 3'd5,
    COND_SQ_LE_I   = 3'd6,
    COND_I_LT_T    = 3'd7
  } cond_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] jump;
    logic            idle;
    logic            seed_wr;
    logic            inner_init;
    logic            inner_step;
    logic            tbl_wr;
    logic            tgt_rd;
    logic            out_load;
    logic            out_zero;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic seed_more;
    logic i_gt_t;
    logic sq_le_i;
    logic i_lt_t;
  } stat_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw            = '0;
    cw.cond       = COND_NEVER;
    cw.jump       = STEP_IDLE;
    unique case (pc)
      STEP_IDLE: begin
        cw.cond = COND_NOSTART;
        cw.jump = STEP_IDLE;
        cw.idle = 1'b1;
      end
      STEP_CHECK: begin
        cw.cond = COND_BAD;
        cw.jump = STEP_BAD;
      end
      STEP_SEED: begin
        cw.cond    = COND_SEED_MORE;
        cw.jump    = STEP_SEED;
        cw.seed_wr = 1'b1;
      end
      STEP_OUTER: begin
        cw.cond       = COND_I_GT_T;
        cw.jump       = STEP_READ;
        cw.inner_init = 1'b1;
      end
      STEP_INNER: begin
        cw.cond       = COND_SQ_LE_I;
        cw.jump       = STEP_INNER;
        cw.inner_step = 1'b1;
      end
      STEP_WRITE: begin
        cw.cond       = COND_I_LT_T;
        cw.jump       = STEP_INNER;
        cw.tbl_wr     = 1'b1;
        cw.inner_init = 1'b1;
      end
      STEP_READ: begin
        cw.cond   = COND_NEVER;
        cw.tgt_rd = 1'b1;
      end
      STEP_OUT: begin
        cw.cond     = COND_ALWAYS;
        cw.jump     = STEP_IDLE;
        cw.out_load = 1'b1;
      end
      STEP_BAD: begin
        cw.cond     = COND_ALWAYS;
        cw.jump     = STEP_IDLE;
        cw.out_zero = 1'b1;
      end
      default: begin
        cw.cond = COND_ALWAYS;
        cw.jump = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/mscnt_ram.sv =====
// ----------------------------------------------------------------------------
// mscnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mscnt_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mscnt_useq.sv =====
// ----------------------------------------------------------------------------
// mscnt_useq
// Step counter and control store; one control word per step, with
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mscnt_useq import mscnt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ctrl_t           cw;
  logic            take;

  always_comb begin
    cw = ucode(pc_r);
    unique case (cw.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NOSTART:   take = !start;
      COND_BAD:       take = stat.bad;
      COND_SEED_MORE: take = stat.seed_more;
      COND_I_GT_T:    take = stat.i_gt_t;
      COND_SQ_LE_I:   take = stat.sq_le_i;
      COND_I_LT_T:    take = stat.i_lt_t;
      default:        take = 1'b1;
    endcase
    pc_nxt = take ? cw.jump : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl = cw;

endmodule

// ===== hdl/mscnt_dp.sv =====
// ----------------------------------------------------------------------------
// mscnt_dp
// Datapath: entry index, incremental square, running minimum, scratch table
// and result register.
// ----------------------------------------------------------------------------
module mscnt_dp import mscnt_pkg::*; #(
  parameter int MAX_N = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [TARGET_W-1:0]    in_target,
  input  ctrl_t                  ctrl,
  output stat_t                  stat,
  output logic                   out_valid,
  output logic [MIN_COUNT_W-1:0] out_min_count
);

  localparam int AW = $clog2(MAX_N + 1);
  localparam int WW = AW + 1;
  localparam int CW = (WW > TARGET_W) ? WW : TARGET_W;

  logic [TARGET_W-1:0]    target_r, target_nxt;
  logic [WW-1:0]          i_r, i_nxt;
  logic [WW-1:0]          sq_r, sq_nxt;
  logic [WW-1:0]          x_r, x_nxt;
  logic [ENTRY_W-1:0]     best_r, best_nxt;
  logic                   pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MIN_COUNT_W-1:0] out_min_count_r, out_min_count_nxt;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [AW-1:0]          raddr;
  logic [ENTRY_W-1:0]     rdata;
  logic [ENTRY_W:0]       cand;
  logic                   step_go;
  logic [CW-1:0]          tgt_c;
  logic [CW-1:0]          i_c;

  mscnt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_N + 1)
  ) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    tgt_c          = CW'(target_r);
    i_c            = CW'(i_r);
    stat.bad       = (target_r == '0) || (tgt_c > CW'(MAX_N));
    stat.seed_more = (i_r != WW'(3));
    stat.i_gt_t    = (i_c > tgt_c);
    stat.i_lt_t    = (i_c < tgt_c);
    stat.sq_le_i   = (sq_r <= i_r);
  end

  always_comb begin
    target_nxt        = target_r;
    i_nxt             = i_r;
    sq_nxt            = sq_r;
    x_nxt             = x_r;
    best_nxt          = best_r;
    out_min_count_nxt = out_min_count_r;
    we                = 1'b0;
    waddr             = AW'(i_r);
    wdata             = best_r;
    step_go           = ctrl.inner_step && stat.sq_le_i;
    raddr             = ctrl.tgt_rd ? AW'(target_r) : AW'(i_r - sq_r);
    cand              = {1'b0, rdata} + (ENTRY_W + 1)'(1);

    if (ctrl.idle && start) begin
      target_nxt = in_target;
      i_nxt      = '0;
    end
    if (ctrl.seed_wr) begin
      we    = 1'b1;
      wdata = i_r[ENTRY_W-1:0];
      i_nxt = i_r + WW'(1);
    end
    if (ctrl.tbl_wr) begin
      we    = 1'b1;
      i_nxt = i_r + WW'(1);
    end
    if (ctrl.inner_init) begin
      x_nxt    = WW'(1);
      sq_nxt   = WW'(1);
      best_nxt = BEST_INIT;
    end
    // (x+1)^2 = x^2 + 2x + 1
    if (step_go) begin
      sq_nxt = sq_r + {x_r[WW-2:0], 1'b1};
      x_nxt  = x_r + WW'(1);
    end
    if (pend_r && (cand < {1'b0, best_r})) begin
      best_nxt = cand[ENTRY_W-1:0];
    end

    pend_nxt      = step_go;
    out_valid_nxt = ctrl.out_load || ctrl.out_zero;
    if (ctrl.out_load) begin
      out_min_count_nxt = rdata;
    end else if (ctrl.out_zero) begin
      out_min_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r        <= target_nxt;
    i_r             <= i_nxt;
    sq_r            <= sq_nxt;
    x_r             <= x_nxt;
    best_r          <= best_nxt;
    out_min_count_r <= out_min_count_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_min_count = out_min_count_r;

endmodule

// ===== hdl/min_squares_count.sv =====
// ----------------------------------------------------------------------------
// min_squares_count
// Fewest perfect squares that sum to a target, by a bottom-up table fill.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the item's single result has been produced. The result is shown on
// out_min_count for one cycle with out_valid, and the receiver cannot stall
// it. A target of zero or above MAX_N gives 0. Otherwise each table entry
// i from 4 to the target is filled by trying each square not above i in
// turn, because the scratch table has one read port and is read once per
// cycle; entries 0 to 3 are seeded first, and the result is read last.
module min_squares_count import mscnt_pkg::*; #(
  parameter int MAX_N = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [TARGET_W-1:0]    in_target,
  output logic                   out_valid,
  output logic [MIN_COUNT_W-1:0] out_min_count
);

  ctrl_t ctrl;
  stat_t stat;

  mscnt_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  mscnt_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_target     (in_target),
    .ctrl          (ctrl),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_min_count (out_min_count)
  );

  assign busy = !ctrl.idle;

endmodule

// ===== hdl/mscnt_chk.sv =====
// ----------------------------------------------------------------------------
// mscnt_chk
// Port-level checks of the fewest-squares block, bound to the top level.
// ----------------------------------------------------------------------------
module mscnt_chk import mscnt_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [MIN_COUNT_W-1:0] out_min_count
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not quiet after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_count <= MIN_COUNT_W'(4))
    else $error("result above four");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result without a finished item");

endmodule

bind min_squares_count mscnt_chk u_chk (.*);
